// ===== rtl/core/prts_pkg.sv =====
// Shared types, codes and constants of the priority round-robin task scheduler.
package prts_pkg;

	localparam int DEF_MAX_TASKS       = 32;
	localparam int DEF_PRIORITY_LEVELS = 32;

	localparam logic [5:0] MODE_THUMB = 6'h3f;
	localparam logic [5:0] MODE_ARM   = 6'h1f;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_BLOCK   = 3'd2,
		OP_UNBLOCK = 3'd3,
		OP_SETPRI  = 3'd4,
		OP_TICK    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_NEW     = 2'd0,
		ST_READY   = 2'd1,
		ST_BLOCKED = 2'd2,
		ST_DELETED = 2'd3
	} st_t;

	typedef enum logic [4:0] {
		UOP_NONE,
		UOP_LOAD,
		UOP_INC_IDX,
		UOP_CREATE,
		UOP_TAKE_RUN,
		UOP_MARKDEL,
		UOP_BLOCK,
		UOP_UNBLOCK,
		UOP_UNL1,
		UOP_UNL2,
		UOP_SETLV,
		UOP_APP1,
		UOP_APP2,
		UOP_APP3,
		UOP_FREE,
		UOP_LVL,
		UOP_DEC_LV,
		UOP_NODE_DEL,
		UOP_ADV_NEXT,
		UOP_ADV_NX,
		UOP_PICK,
		UOP_FINISH
	} uop_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        use_current;
		logic [4:0]  task_slot;
		logic [4:0]  priority_req;
		logic [31:0] entry_address;
		logic [31:0] argument;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  slot_out;
		logic        running_valid;
		logic [4:0]  running_slot;
		logic        start_fresh;
		logic [31:0] start_address;
		logic [31:0] start_argument;
		logic [5:0]  mode_bits;
	} result_t;

	typedef struct packed {
		uop_t uop;
		logic set_ok;
		logic use_c;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       use_cur;
		logic       tgt_v;
		logic       create_ok;
		logic       prio_ok;
		logic       run_v;
		logic       free_hit;
		logic       idx_last;
		logic       c_v;
		logic       c_run;
		logic       c_del;
		logic       lv_zero;
	} sts_t;

endpackage

// ===== rtl/core/prts_dp.sv =====
// Datapath of the task scheduler: task table, level lists and result register.
module prts_dp #(
	parameter int MAX_TASKS       = prts_pkg::DEF_MAX_TASKS,
	parameter int PRIORITY_LEVELS = prts_pkg::DEF_PRIORITY_LEVELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prts_pkg::item_t   item,
	input  prts_pkg::cmd_t    cmd,
	output prts_pkg::sts_t    sts,
	output prts_pkg::result_t result,
	output logic              done
);
	import prts_pkg::*;

	localparam int SW = $clog2(MAX_TASKS);
	localparam int LW = $clog2(PRIORITY_LEVELS);
	localparam int PW = SW + 1;

	logic          used_q [MAX_TASKS];
	st_t           st_q   [MAX_TASKS];
	logic [LW-1:0] lvl_q  [MAX_TASKS];
	logic [PW-1:0] nxt_q  [MAX_TASKS];
	logic [PW-1:0] prv_q  [MAX_TASKS];
	logic [31:0]   ent_q  [MAX_TASKS];
	logic [31:0]   arg_q  [MAX_TASKS];
	logic [PW-1:0] head_q [PRIORITY_LEVELS];
	logic [PW-1:0] tail_q [PRIORITY_LEVELS];

	item_t         item_q;
	logic [SW-1:0] s_q, idx_q, so_q, run_q;
	logic          tgt_v_q, run_v_q, ok_q, fresh_q, done_q;
	logic [LW-1:0] lv_q, lvc_q;
	logic [PW-1:0] p_q, n_q, t_q, c_q, nx_q;
	logic [31:0]   saddr_q, sarg_q;
	logic [5:0]    mode_q;
	result_t       res_q;

	logic [SW-1:0] ra, tgt_idx;
	logic [LW-1:0] la;
	st_t           st_r;
	logic [PW-1:0] nx_r, pv_r, hd_r, tl_r, s_ptr;
	logic [LW-1:0] lv_r;
	logic          tgt_v, op_tgt, prio_ok;

	assign ra    = cmd.use_c ? c_q[SW-1:0] : s_q;
	assign la    = cmd.use_c ? lvc_q : lv_q;
	assign st_r  = st_q[ra];
	assign nx_r  = nxt_q[ra];
	assign pv_r  = prv_q[ra];
	assign lv_r  = lvl_q[ra];
	assign hd_r  = head_q[la];
	assign tl_r  = tail_q[la];
	assign s_ptr = {1'b1, s_q};

	// Target of remove, block, unblock and set priority, resolved as the item arrives.
	assign op_tgt  = (item.op == OP_REMOVE) || (item.op == OP_BLOCK) ||
	                 (item.op == OP_UNBLOCK) || (item.op == OP_SETPRI);
	assign tgt_idx = item.use_current ? run_q : SW'(item.task_slot);
	assign tgt_v   = op_tgt && (item.use_current ? run_v_q :
	                 ((32'(item.task_slot) < MAX_TASKS) && used_q[SW'(item.task_slot)]));
	assign prio_ok = 32'(item_q.priority_req) < PRIORITY_LEVELS;

	assign sts.op        = item_q.op;
	assign sts.use_cur   = item_q.use_current;
	assign sts.tgt_v     = tgt_v_q;
	assign sts.create_ok = (item_q.entry_address != 32'd0) && prio_ok;
	assign sts.prio_ok   = prio_ok;
	assign sts.run_v     = run_v_q;
	assign sts.free_hit  = !used_q[idx_q];
	assign sts.idx_last  = idx_q == SW'(MAX_TASKS - 1);
	assign sts.c_v       = c_q[SW];
	assign sts.c_run     = c_q[SW] && ((st_r == ST_NEW) || (st_r == ST_READY));
	assign sts.c_del     = c_q[SW] && (st_r == ST_DELETED);
	assign sts.lv_zero   = lvc_q == '0;

	assign result = res_q;
	assign done   = done_q;

	// Control state: slot occupancy, list heads and tails, running task flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) used_q[i] <= 1'b0;
			for (int i = 0; i < PRIORITY_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			run_v_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.uop == UOP_FINISH;
			unique case (cmd.uop)
				UOP_CREATE: used_q[idx_q] <= 1'b1;
				UOP_UNL2: begin
					if (hd_r == s_ptr) head_q[la] <= n_q;
					if (tl_r == s_ptr) tail_q[la] <= p_q;
				end
				UOP_APP2: begin
					if (!hd_r[SW]) head_q[la] <= s_ptr;
					tail_q[la] <= s_ptr;
				end
				UOP_FREE: begin
					used_q[s_q] <= 1'b0;
					if (run_v_q && (run_q == s_q)) run_v_q <= 1'b0;
				end
				UOP_PICK: run_v_q <= c_q[SW];
				default: ;
			endcase
		end
	end

	// Task table payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.set_ok) ok_q <= 1'b1;
		unique case (cmd.uop)
			UOP_LOAD: begin
				item_q  <= item;
				s_q     <= tgt_idx;
				tgt_v_q <= tgt_v;
				idx_q   <= '0;
				lvc_q   <= LW'(PRIORITY_LEVELS - 1);
				ok_q    <= 1'b0;
				so_q    <= tgt_v ? tgt_idx : '0;
				fresh_q <= 1'b0;
				saddr_q <= '0;
				sarg_q  <= '0;
				mode_q  <= MODE_ARM;
			end
			UOP_INC_IDX: idx_q <= idx_q + 1'b1;
			UOP_CREATE: begin
				st_q[idx_q]  <= ST_NEW;
				lvl_q[idx_q] <= LW'(item_q.priority_req);
				ent_q[idx_q] <= item_q.entry_address;
				arg_q[idx_q] <= item_q.argument;
				s_q          <= idx_q;
				so_q         <= idx_q;
				lv_q         <= LW'(item_q.priority_req);
			end
			UOP_TAKE_RUN: s_q <= run_q;
			UOP_MARKDEL: st_q[s_q] <= ST_DELETED;
			UOP_BLOCK: begin
				if (tgt_v_q && ((st_r == ST_READY) || (st_r == ST_BLOCKED))) begin
					st_q[s_q] <= ST_BLOCKED;
					ok_q      <= 1'b1;
				end
			end
			UOP_UNBLOCK: begin
				if (tgt_v_q && (st_r == ST_BLOCKED)) begin
					st_q[s_q] <= ST_READY;
					ok_q      <= 1'b1;
				end
			end
			UOP_UNL1: begin
				lv_q <= lv_r;
				p_q  <= pv_r;
				n_q  <= nx_r;
			end
			UOP_UNL2: begin
				if (p_q[SW]) nxt_q[p_q[SW-1:0]] <= n_q;
				if (n_q[SW]) prv_q[n_q[SW-1:0]] <= p_q;
			end
			UOP_SETLV: begin
				lvl_q[s_q] <= LW'(item_q.priority_req);
				lv_q       <= LW'(item_q.priority_req);
			end
			UOP_APP1: t_q <= tl_r;
			UOP_APP2: begin
				prv_q[s_q] <= t_q;
				nxt_q[s_q] <= '0;
			end
			UOP_APP3: if (t_q[SW]) nxt_q[t_q[SW-1:0]] <= s_ptr;
			UOP_LVL: c_q <= hd_r;
			UOP_DEC_LV: lvc_q <= lvc_q - 1'b1;
			UOP_NODE_DEL: begin
				s_q  <= c_q[SW-1:0];
				nx_q <= nx_r;
			end
			UOP_ADV_NEXT: c_q <= nx_r;
			UOP_ADV_NX: c_q <= nx_q;
			UOP_PICK: begin
				run_q <= c_q[SW-1:0];
				if (c_q[SW]) begin
					ok_q <= 1'b1;
					so_q <= c_q[SW-1:0];
					if (st_r == ST_NEW) begin
						st_q[ra] <= ST_READY;
						fresh_q  <= 1'b1;
						saddr_q  <= {ent_q[ra][31:1], 1'b0};
						sarg_q   <= arg_q[ra];
						mode_q   <= ent_q[ra][0] ? MODE_THUMB : MODE_ARM;
					end
				end
			end
			UOP_FINISH: begin
				res_q.ok             <= ok_q;
				res_q.slot_out       <= 5'(so_q);
				res_q.running_valid  <= run_v_q;
				res_q.running_slot   <= run_v_q ? 5'(run_q) : 5'd0;
				res_q.start_fresh    <= fresh_q;
				res_q.start_address  <= saddr_q;
				res_q.start_argument <= sarg_q;
				res_q.mode_bits      <= mode_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/prts_ctrl.sv =====
// Controller of the task scheduler: sequences the datapath steps of each operation.
module prts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  prts_pkg::sts_t sts,
	output prts_pkg::cmd_t cmd
);
	import prts_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_DISP  = 15'h0002,
		S_SCANF = 15'h0004,
		S_U1    = 15'h0008,
		S_U2    = 15'h0010,
		S_SETLV = 15'h0020,
		S_A1    = 15'h0040,
		S_A2    = 15'h0080,
		S_A3    = 15'h0100,
		S_FREE  = 15'h0200,
		S_LVL   = 15'h0400,
		S_NODE  = 15'h0800,
		S_ADV   = 15'h1000,
		S_PICK  = 15'h2000,
		S_FIN   = 15'h4000
	} state_t;

	typedef enum logic [2:0] {
		CTX_CREATE,
		CTX_REMOVE,
		CTX_SETPRI,
		CTX_ROT,
		CTX_SDEL
	} ctx_t;

	state_t state_q, state_d;
	ctx_t   ctx_q, ctx_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		ctx_d   = ctx_q;
		cmd     = '{uop: UOP_NONE, set_ok: 1'b0, use_c: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.uop = UOP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				unique case (sts.op)
					OP_CREATE: if (sts.create_ok) state_d = S_SCANF;
					OP_REMOVE: begin
						if (sts.tgt_v) begin
							if (sts.use_cur) begin
								cmd.uop    = UOP_MARKDEL;
								cmd.set_ok = 1'b1;
							end else begin
								ctx_d   = CTX_REMOVE;
								state_d = S_U1;
							end
						end
					end
					OP_BLOCK:   cmd.uop = UOP_BLOCK;
					OP_UNBLOCK: cmd.uop = UOP_UNBLOCK;
					OP_SETPRI: begin
						if (sts.tgt_v && sts.prio_ok) begin
							ctx_d   = CTX_SETPRI;
							state_d = S_U1;
						end
					end
					OP_TICK: begin
						if (sts.run_v) begin
							cmd.uop = UOP_TAKE_RUN;
							ctx_d   = CTX_ROT;
							state_d = S_U1;
						end else begin
							state_d = S_LVL;
						end
					end
					default: ;
				endcase
			end
			S_SCANF: begin
				if (sts.free_hit) begin
					cmd.uop    = UOP_CREATE;
					cmd.set_ok = 1'b1;
					ctx_d      = CTX_CREATE;
					state_d    = S_A1;
				end else if (sts.idx_last) begin
					state_d = S_FIN;
				end else begin
					cmd.uop = UOP_INC_IDX;
				end
			end
			S_U1: begin
				cmd.uop = UOP_UNL1;
				state_d = S_U2;
			end
			S_U2: begin
				cmd.uop = UOP_UNL2;
				priority case (ctx_q)
					CTX_SETPRI: state_d = S_SETLV;
					CTX_ROT:    state_d = S_A1;
					default:    state_d = S_FREE;
				endcase
			end
			S_SETLV: begin
				cmd.uop    = UOP_SETLV;
				cmd.set_ok = 1'b1;
				state_d    = S_A1;
			end
			S_A1: begin
				cmd.uop = UOP_APP1;
				state_d = S_A2;
			end
			S_A2: begin
				cmd.uop = UOP_APP2;
				state_d = S_A3;
			end
			S_A3: begin
				cmd.uop = UOP_APP3;
				state_d = (ctx_q == CTX_ROT) ? S_LVL : S_FIN;
			end
			S_FREE: begin
				cmd.uop    = UOP_FREE;
				cmd.set_ok = ctx_q == CTX_REMOVE;
				state_d    = (ctx_q == CTX_SDEL) ? S_ADV : S_FIN;
			end
			S_LVL: begin
				cmd.uop   = UOP_LVL;
				cmd.use_c = 1'b1;
				state_d   = S_NODE;
			end
			S_NODE: begin
				cmd.use_c = 1'b1;
				priority if (!sts.c_v) begin
					if (sts.lv_zero) begin
						state_d = S_PICK;
					end else begin
						cmd.uop = UOP_DEC_LV;
						state_d = S_LVL;
					end
				end else if (sts.c_run) begin
					state_d = S_PICK;
				end else if (sts.c_del) begin
					cmd.uop = UOP_NODE_DEL;
					ctx_d   = CTX_SDEL;
					state_d = S_U1;
				end else begin
					cmd.uop = UOP_ADV_NEXT;
				end
			end
			S_ADV: begin
				cmd.uop = UOP_ADV_NX;
				state_d = S_NODE;
			end
			S_PICK: begin
				cmd.uop   = UOP_PICK;
				cmd.use_c = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				cmd.uop = UOP_FINISH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctx_q   <= CTX_CREATE;
		end else begin
			state_q <= state_d;
			ctx_q   <= ctx_d;
		end
	end

endmodule

// ===== rtl/core/priority_round_robin_task_scheduler.sv =====
// Top level of the fixed-priority round-robin task scheduler.
//
// Channel   Direction  Handshake             Payload
// command   in         start, busy           item   (prts_pkg::item_t)
// result    out        done, one-cycle pulse result (prts_pkg::result_t)
//
// A transaction is accepted on a rising edge with start high and busy low; busy
// then stays high until the result is registered, and done is registered with it.
// Create scans the slots in order for a free one, passing occupied slots one at a
// time; block, unblock and mark-deleted finish without any list work. A tick moves
// the running task, if any, to its level's tail, then scans the levels from the highest
// index down, passing blocked tasks and freeing each deleted task it meets, until it
// finds a task to run or runs out of levels; the single-ported list walk sets its length.
// Reset clears slot occupancy, all list heads and tails and the running task at once.
// The receiver cannot stall: done is high for exactly one cycle per result, result holds
// until the next one, and a new command transaction may be started in that same cycle.
module priority_round_robin_task_scheduler #(
	parameter int MAX_TASKS       = prts_pkg::DEF_MAX_TASKS,
	parameter int PRIORITY_LEVELS = prts_pkg::DEF_PRIORITY_LEVELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  prts_pkg::item_t   item,
	output logic              done,
	output prts_pkg::result_t result
);
	import prts_pkg::*;

	// Commands from the controller and status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	// The controller walks each operation through the list unlink, append and
	// level-scan steps it needs; the datapath holds all task and list storage.
	prts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	prts_dp #(
		.MAX_TASKS       (MAX_TASKS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

endmodule
